/* design/generational_handle_allocator_core_defines.svh */
// Assertion macros shared by the generational handle allocator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define GHAC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GHAC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ghac_pkg.sv */
// Types and constants of the generational handle allocator.
// No dependencies; used by every module of the block.
package ghac_pkg;

  localparam int IDX_W     = 12;
  localparam int GEN_W     = 10;
  localparam int CNT_W     = 13;
  localparam int OP_W      = 2;
  localparam int STATUS_W  = 2;
  localparam int THR_W     = 13;
  localparam int MAX_SLOTS = 4096;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1024);

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  // Command class decided at the front.
  typedef enum logic [2:0] {
    CMD_FRESH,
    CMD_RECYCLE,
    CMD_FULL,
    CMD_FREE,
    CMD_FREE_BAD,
    CMD_CHECK,
    CMD_CHECK_BAD,
    CMD_NOP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [GEN_W-1:0]  gen;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] slots_in_use;
    logic [CNT_W-1:0] fifo_count;
  } pool_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RECYCLE,
    BK_EXEC
  } bk_state_t;

endpackage

/* design/ghac_front.sv */
// Front end: takes commands, holds the reuse threshold, classifies each command.
// Depends on ghac_pkg.
module ghac_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic [ghac_pkg::OP_W-1:0]    op,
  input  logic [ghac_pkg::IDX_W-1:0]   entity_index,
  input  logic [ghac_pkg::GEN_W-1:0]   entity_generation,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ghac_pkg::THR_W-1:0]   cfg_data,
  input  ghac_pkg::pool_stat_t         stat,
  output logic                         push,
  output ghac_pkg::cmd_t               entry
);
  import ghac_pkg::*;

  logic [THR_W-1:0] reuse_threshold;
  logic             have_fresh;
  logic             want_fresh;
  logic             in_range;

  assign cfg_ready = !busy;
  assign push      = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      reuse_threshold <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      reuse_threshold <= cfg_data;
    end
  end

  always_comb begin
    have_fresh = stat.slots_in_use < CNT_W'(MAX_SLOTS);
    want_fresh = (stat.fifo_count < reuse_threshold) || (stat.fifo_count == '0);
    in_range   = {1'b0, entity_index} < stat.slots_in_use;
    entry.idx  = entity_index;
    entry.gen  = entity_generation;
    case (op)
      OP_ALLOC: begin
        if (have_fresh && want_fresh) begin
          entry.kind = CMD_FRESH;
        end else if (stat.fifo_count != '0) begin
          entry.kind = CMD_RECYCLE;
        end else begin
          entry.kind = CMD_FULL;
        end
      end
      OP_FREE:  entry.kind = in_range ? CMD_FREE : CMD_FREE_BAD;
      OP_CHECK: entry.kind = in_range ? CMD_CHECK : CMD_CHECK_BAD;
      default:  entry.kind = CMD_NOP;
    endcase
  end

endmodule

/* design/ghac_queue.sv */
// Two-entry command queue between the front and back ends.
// Depends on ghac_pkg.
module ghac_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ghac_pkg::cmd_t  push_cmd,
  input  logic            pop,
  output logic            nonempty,
  output ghac_pkg::cmd_t  head
);
  import ghac_pkg::*;

  localparam int DEPTH = 2;

  cmd_t       slots [DEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign nonempty = count != 2'd0;
  assign head     = slots[rd_ptr];
  assign do_push  = push && (count != 2'(DEPTH));
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

/* design/ghac_back.sv */
// Back end: generation and free-list memories, pool counters, result register.
// Depends on ghac_pkg and generational_handle_allocator_core_defines.svh.
`include "generational_handle_allocator_core_defines.svh"

module ghac_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  ghac_pkg::cmd_t                    q_head,
  output logic                              q_pop,
  output ghac_pkg::pool_stat_t              stat,
  output logic                              idle,
  output logic                              done,
  output logic [ghac_pkg::IDX_W-1:0]        out_index,
  output logic [ghac_pkg::GEN_W-1:0]        out_generation,
  output logic                              fresh,
  output logic                              valid_res,
  output logic [ghac_pkg::STATUS_W-1:0]     status
);
  import ghac_pkg::*;

  bk_state_t state;
  bk_state_t state_next;
  cmd_t      cur;

  logic [GEN_W-1:0] gen_mem  [0:MAX_SLOTS-1];
  logic [IDX_W-1:0] fifo_mem [0:MAX_SLOTS-1];
  logic [GEN_W-1:0] gen_rd;
  logic [IDX_W-1:0] fifo_rd;
  logic [IDX_W-1:0] gen_raddr;

  logic [CNT_W-1:0] slots_in_use;
  logic [CNT_W-1:0] fifo_count;
  logic [IDX_W-1:0] fifo_head;
  logic [IDX_W-1:0] fifo_tail;

  logic                exec;
  logic                gen_match;
  logic                gen_we;
  logic [IDX_W-1:0]    gen_waddr;
  logic [GEN_W-1:0]    gen_wdata;
  logic                fifo_push;
  logic                fifo_pop;
  logic                take_fresh;
  logic [IDX_W-1:0]    res_index;
  logic [GEN_W-1:0]    res_gen;
  logic                res_fresh;
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;

  assign stat.slots_in_use = slots_in_use;
  assign stat.fifo_count   = fifo_count;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = (q_head.kind == CMD_RECYCLE) ? BK_RECYCLE : BK_EXEC;
        end
      end
      BK_RECYCLE: state_next = BK_EXEC;
      BK_EXEC:    state_next = BK_IDLE;
      default:    state_next = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop     = (state == BK_IDLE) && q_valid;
    idle      = (state == BK_IDLE);
    exec      = (state == BK_EXEC);
    gen_raddr = (state == BK_RECYCLE) ? fifo_rd : q_head.idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
  end

  // Work out the command in the execute cycle
  always_comb begin
    gen_match  = gen_rd == cur.gen;
    gen_we     = 1'b0;
    gen_waddr  = cur.idx;
    gen_wdata  = gen_rd + 1'b1;
    fifo_push  = 1'b0;
    fifo_pop   = 1'b0;
    take_fresh = 1'b0;
    res_index  = '0;
    res_gen    = '0;
    res_fresh  = 1'b0;
    res_valid  = 1'b0;
    res_status = ST_OK;
    case (cur.kind)
      CMD_FRESH: begin
        take_fresh = exec;
        gen_we     = exec;
        gen_waddr  = slots_in_use[IDX_W-1:0];
        gen_wdata  = '0;
        res_index  = slots_in_use[IDX_W-1:0];
        res_fresh  = 1'b1;
      end
      CMD_RECYCLE: begin
        fifo_pop  = exec;
        res_index = fifo_rd;
        res_gen   = gen_rd;
      end
      CMD_FULL: res_status = ST_FULL;
      CMD_FREE: begin
        if (gen_match) begin
          res_valid = 1'b1;
          gen_we    = exec;
          fifo_push = exec && (fifo_count < CNT_W'(MAX_SLOTS));
        end else begin
          res_status = ST_BAD_FREE;
        end
      end
      CMD_FREE_BAD: res_status = ST_BAD_FREE;
      CMD_CHECK:    res_valid  = gen_match;
      default: begin
      end
    endcase
  end

  // Memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    gen_rd <= gen_mem[gen_raddr];
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[fifo_tail] <= cur.idx;
    end
    fifo_rd <= fifo_mem[fifo_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= '0;
      fifo_count   <= '0;
      fifo_head    <= '0;
      fifo_tail    <= '0;
    end else begin
      if (take_fresh) slots_in_use <= slots_in_use + 1'b1;
      if (fifo_pop) begin
        fifo_head <= (fifo_head == IDX_W'(MAX_SLOTS - 1)) ? '0 : fifo_head + 1'b1;
      end
      if (fifo_push) begin
        fifo_tail <= (fifo_tail == IDX_W'(MAX_SLOTS - 1)) ? '0 : fifo_tail + 1'b1;
      end
      fifo_count <= fifo_count + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_index      <= res_index;
      out_generation <= res_gen;
      fresh          <= res_fresh;
      valid_res      <= res_valid;
      status         <= res_status;
    end
  end

  `GHAC_ASSERT_IMPL(a_count_cap, clk, rst, 1'b1, fifo_count <= CNT_W'(MAX_SLOTS), "free list overflow")
  `GHAC_ASSERT_NEXT(a_exec_strobe, clk, rst, exec, done, "execute cycle gave no result strobe")
  `GHAC_ASSERT_IMPL(a_strobe_src, clk, rst, done, $past(exec), "result strobe without execute cycle")
  `GHAC_ASSERT_IMPL(a_err_clean, clk, rst, done && (status != ST_OK), !fresh && !valid_res && (out_index == '0), "error result carries data")

endmodule

/* design/generational_handle_allocator_core.sv */
// Top level of the generational handle allocator.
// Depends on ghac_pkg, ghac_front, ghac_queue and ghac_back.
//
// Usage:
//   Command channel: drive op, entity_index and entity_generation with start
//   high; the command transfers at a rising edge where start is high and busy
//   is low. op selects allocate, free handle or check handle.
//   Result channel: done is high for exactly one cycle with out_index,
//   out_generation, fresh, valid_res and status; the result transfers at the
//   edge ending that cycle. The receiver cannot stall the block.
//   Configuration: cfg_data carries reuse_threshold and transfers when
//   cfg_valid and cfg_ready are high; cfg_ready is high whenever busy is low.
//   Sequence: the back end takes the command into its execute state, or
//   into a recycle state first for an allocate that recycles a freed slot
//   (the free-list read must land before the generation read), and done
//   follows the execute state. busy drops in the done cycle, so the next
//   command transfers no earlier than the edge ending it.
//   Reset (rst, synchronous): pool and free list empty, threshold 1024,
//   no result pending. Memory contents are not cleared; entries are used
//   only after being written.
module generational_handle_allocator_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [ghac_pkg::OP_W-1:0]         op,
  input  logic [ghac_pkg::IDX_W-1:0]        entity_index,
  input  logic [ghac_pkg::GEN_W-1:0]        entity_generation,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ghac_pkg::THR_W-1:0]        cfg_data,
  output logic                              done,
  output logic [ghac_pkg::IDX_W-1:0]        out_index,
  output logic [ghac_pkg::GEN_W-1:0]        out_generation,
  output logic                              fresh,
  output logic                              valid_res,
  output logic [ghac_pkg::STATUS_W-1:0]     status
);
  import ghac_pkg::*;

  pool_stat_t stat;
  cmd_t       push_cmd;
  cmd_t       q_head;
  logic       push;
  logic       q_valid;
  logic       q_pop;
  logic       back_idle;

  // Hold off new commands until the queue drains and the back end has
  // retired its command, so classification always sees settled counters.
  assign busy = q_valid || !back_idle;

  ghac_front u_front (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .op                (op),
    .entity_index      (entity_index),
    .entity_generation (entity_generation),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data),
    .stat              (stat),
    .push              (push),
    .entry             (push_cmd)
  );

  ghac_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .nonempty (q_valid),
    .head     (q_head)
  );

  ghac_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .stat           (stat),
    .idle           (back_idle),
    .done           (done),
    .out_index      (out_index),
    .out_generation (out_generation),
    .fresh          (fresh),
    .valid_res      (valid_res),
    .status         (status)
  );

endmodule
